@@ rtl/core/lc3_iec_pkg.sv @@
// ----------------------------------------------------------------------------
// lc3_iec_pkg
// Shared codes and sizes of the LC-3 instruction execute core: command,
// request kind, opcode and pending access codes, config register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package lc3_iec_pkg;

    localparam int unsigned WORD_W   = 16;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned FLAGS_W  = 3;
    localparam int unsigned RIDX_W   = 3;
    localparam int unsigned PEND_W   = 3;
    localparam int unsigned OP_W     = 4;
    localparam int unsigned CFG_IDX_W = 2;

    localparam int unsigned RES_DEPTH = 4;

    // command codes
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSTR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DATA  = 2'd2;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_FETCH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd3;

    // pending access codes
    localparam logic [PEND_W-1:0] PEND_NONE    = 3'd0;
    localparam logic [PEND_W-1:0] PEND_LOAD    = 3'd1;
    localparam logic [PEND_W-1:0] PEND_LDI_PTR = 3'd2;
    localparam logic [PEND_W-1:0] PEND_STI_PTR = 3'd3;
    localparam logic [PEND_W-1:0] PEND_RTI     = 3'd4;

    // opcodes
    localparam logic [OP_W-1:0] OP_BR   = 4'h0;
    localparam logic [OP_W-1:0] OP_ADD  = 4'h1;
    localparam logic [OP_W-1:0] OP_LD   = 4'h2;
    localparam logic [OP_W-1:0] OP_ST   = 4'h3;
    localparam logic [OP_W-1:0] OP_JSR  = 4'h4;
    localparam logic [OP_W-1:0] OP_AND  = 4'h5;
    localparam logic [OP_W-1:0] OP_LDR  = 4'h6;
    localparam logic [OP_W-1:0] OP_STR  = 4'h7;
    localparam logic [OP_W-1:0] OP_RTI  = 4'h8;
    localparam logic [OP_W-1:0] OP_NOT  = 4'h9;
    localparam logic [OP_W-1:0] OP_LDI  = 4'hA;
    localparam logic [OP_W-1:0] OP_STI  = 4'hB;
    localparam logic [OP_W-1:0] OP_JMP  = 4'hC;
    localparam logic [OP_W-1:0] OP_RSV  = 4'hD;
    localparam logic [OP_W-1:0] OP_LEA  = 4'hE;
    localparam logic [OP_W-1:0] OP_TRAP = 4'hF;

    // condition codes
    localparam logic [FLAGS_W-1:0] CC_N = 3'b100;
    localparam logic [FLAGS_W-1:0] CC_Z = 3'b010;
    localparam logic [FLAGS_W-1:0] CC_P = 3'b001;

    // stack pointer and link register
    localparam logic [RIDX_W-1:0] REG_SP   = 3'd5;
    localparam logic [RIDX_W-1:0] REG_LINK = 3'd7;

    // config registers
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_VEC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ILL_VEC = 2'd1;

    localparam logic [WORD_W-1:0] IRQ_VEC_RESET = 16'h0001;
    localparam logic [WORD_W-1:0] ILL_VEC_RESET = 16'h0002;

endpackage

`default_nettype wire

@@ rtl/core/lc3_instruction_execute_core_top.sv @@
// ----------------------------------------------------------------------------
// lc3_instruction_execute_core_top
// LC-3 core whose memory traffic travels as items: steps, instruction words
// and read data come in, fetch, read, write and completion results go out.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per transfer (cmd, data_word, irq_request).
//   m_ channel: one or two results per item, m_last on the final one.
//   cfg channel: cfg_index 0 is the interrupt vector, 1 the reserved opcode
//   vector; always ready. It must be written while the core is idle; the
//   core itself does not enforce this. An accepted item is held in the
//   input register and executes there against the register file, PC, flags
//   and pending access; its results enter a four-entry result queue at the
//   next edge, and the first result shows on m_ from that queue.
//   Throughput is one item per cycle while the queue has room for two
//   results; an interrupt step yields two results. Items ignored by the core
//   (steps and instructions while an access is pending, read data while
//   none is, or cmd 3) produce nothing. The input register only executes
//   while the queue has room for two results, so a stalled m_ side holds
//   s_ready low once more than two results wait; nothing is lost.
//   Reset (aresetn low, synchronous) clears registers, PC, interrupt enable,
//   pending access and the result queue, sets flags to Z, restores vectors.
// ----------------------------------------------------------------------------
`default_nettype none

module lc3_instruction_execute_core_top #(
    parameter int unsigned RES_DEPTH = lc3_iec_pkg::RES_DEPTH
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [lc3_iec_pkg::CMD_W-1:0]       s_cmd,
    input  wire logic [lc3_iec_pkg::WORD_W-1:0]      s_data_word,
    input  wire logic                                s_irq_request,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [lc3_iec_pkg::KIND_W-1:0]           m_req_kind,
    output logic [lc3_iec_pkg::WORD_W-1:0]           m_req_address,
    output logic [lc3_iec_pkg::WORD_W-1:0]           m_write_data,
    output logic [lc3_iec_pkg::WORD_W-1:0]           m_pc_value,
    output logic [lc3_iec_pkg::FLAGS_W-1:0]          m_cond_flags,
    output logic                                     m_dest_written,
    output logic [lc3_iec_pkg::RIDX_W-1:0]           m_dest_index,
    output logic [lc3_iec_pkg::WORD_W-1:0]           m_dest_value,
    output logic                                     m_last,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [lc3_iec_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lc3_iec_pkg::WORD_W-1:0]      cfg_data
);

    localparam int unsigned PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);
    localparam int unsigned NREGS = 2 ** lc3_iec_pkg::RIDX_W;

    typedef struct packed {
        logic [lc3_iec_pkg::KIND_W-1:0]  req_kind;
        logic [lc3_iec_pkg::WORD_W-1:0]  req_address;
        logic [lc3_iec_pkg::WORD_W-1:0]  write_data;
        logic [lc3_iec_pkg::WORD_W-1:0]  pc_value;
        logic [lc3_iec_pkg::FLAGS_W-1:0] cond_flags;
        logic                            dest_written;
        logic [lc3_iec_pkg::RIDX_W-1:0]  dest_index;
        logic [lc3_iec_pkg::WORD_W-1:0]  dest_value;
        logic                            last;
    } res_t;

    function automatic logic [lc3_iec_pkg::FLAGS_W-1:0] flags_of(
        input logic [lc3_iec_pkg::WORD_W-1:0] v
    );
        logic [lc3_iec_pkg::FLAGS_W-1:0] f;
        if (v[lc3_iec_pkg::WORD_W-1]) begin
            f = lc3_iec_pkg::CC_N;
        end else if (v == '0) begin
            f = lc3_iec_pkg::CC_Z;
        end else begin
            f = lc3_iec_pkg::CC_P;
        end
        return f;
    endfunction

    // input register
    logic                               in_vld_reg;
    logic [lc3_iec_pkg::CMD_W-1:0]      in_cmd_reg;
    logic [lc3_iec_pkg::WORD_W-1:0]     in_word_reg;
    logic                               in_irq_reg;

    // architectural state
    logic [lc3_iec_pkg::WORD_W-1:0]     gr_reg [NREGS];
    logic [lc3_iec_pkg::WORD_W-1:0]     pc_reg, pc_next;
    logic [lc3_iec_pkg::FLAGS_W-1:0]    cc_reg, cc_next;
    logic                               ie_reg, ie_next;
    logic [lc3_iec_pkg::PEND_W-1:0]     pend_reg, pend_next;
    logic [lc3_iec_pkg::RIDX_W-1:0]     preg_reg, preg_next;
    logic [lc3_iec_pkg::WORD_W-1:0]     irq_vec_reg;
    logic [lc3_iec_pkg::WORD_W-1:0]     ill_vec_reg;

    // result queue
    res_t                               fifo_reg [RES_DEPTH];
    logic [PTR_W-1:0]                   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]                   cnt_reg;

    logic                               exec_go;
    logic                               pop;
    logic [1:0]                         push_n;
    res_t                               res0, res1;

    logic                               gr_we;
    logic [lc3_iec_pkg::RIDX_W-1:0]     gr_wi;
    logic [lc3_iec_pkg::WORD_W-1:0]     gr_wd;

    logic [lc3_iec_pkg::OP_W-1:0]       op;
    logic [lc3_iec_pkg::RIDX_W-1:0]     dr, sr1, rc_idx;
    logic [lc3_iec_pkg::WORD_W-1:0]     rd_a, rd_b, rd_c, sp;
    logic [lc3_iec_pkg::WORD_W-1:0]     src2, off6, off9, off11, pc1;

    assign op     = in_word_reg[15:12];
    assign dr     = in_word_reg[11:9];
    assign sr1    = in_word_reg[8:6];
    assign rc_idx = (in_cmd_reg == lc3_iec_pkg::CMD_DATA) ? preg_reg : dr;
    assign rd_a   = gr_reg[sr1];
    assign rd_b   = gr_reg[in_word_reg[2:0]];
    assign rd_c   = gr_reg[rc_idx];
    assign sp     = gr_reg[lc3_iec_pkg::REG_SP];
    assign off6   = {{10{in_word_reg[5]}}, in_word_reg[5:0]};
    assign off9   = {{7{in_word_reg[8]}}, in_word_reg[8:0]};
    assign off11  = {{5{in_word_reg[10]}}, in_word_reg[10:0]};
    assign src2   = in_word_reg[5] ? {{11{in_word_reg[4]}}, in_word_reg[4:0]} : rd_b;
    assign pc1    = pc_reg + 16'd1;

    assign exec_go   = in_vld_reg && (cnt_reg <= CNT_W'(RES_DEPTH - 2));
    assign s_ready   = !in_vld_reg || exec_go;
    assign cfg_ready = 1'b1;
    assign pop       = m_valid && m_ready;

    always_comb begin
        logic [lc3_iec_pkg::WORD_W-1:0] v;
        v         = '0;
        pc_next   = pc_reg;
        cc_next   = cc_reg;
        ie_next   = ie_reg;
        pend_next = pend_reg;
        preg_next = preg_reg;
        gr_we     = 1'b0;
        gr_wi     = '0;
        gr_wd     = '0;
        push_n    = 2'd0;
        res0      = '0;
        res1      = '0;
        res0.last = 1'b1;
        res1.last = 1'b1;

        unique case (in_cmd_reg)
            lc3_iec_pkg::CMD_STEP: begin
                if (pend_reg == lc3_iec_pkg::PEND_NONE) begin
                    if (ie_reg && in_irq_reg) begin
                        gr_we   = 1'b1;
                        gr_wi   = lc3_iec_pkg::REG_SP;
                        gr_wd   = sp + 16'd1;
                        ie_next = 1'b0;
                        pc_next = irq_vec_reg;
                        res0.req_kind     = lc3_iec_pkg::KIND_WRITE;
                        res0.req_address  = sp;
                        res0.write_data   = pc_reg;
                        res0.dest_written = 1'b1;
                        res0.dest_index   = lc3_iec_pkg::REG_SP;
                        res0.dest_value   = sp + 16'd1;
                        res0.last         = 1'b0;
                        res1.req_kind     = lc3_iec_pkg::KIND_FETCH;
                        res1.req_address  = irq_vec_reg;
                        push_n = 2'd2;
                    end else begin
                        res0.req_kind    = lc3_iec_pkg::KIND_FETCH;
                        res0.req_address = pc_reg;
                        push_n = 2'd1;
                    end
                end
            end
            lc3_iec_pkg::CMD_INSTR: begin
                if (pend_reg == lc3_iec_pkg::PEND_NONE) begin
                    push_n  = 2'd1;
                    pc_next = pc1;
                    res0.req_kind = lc3_iec_pkg::KIND_DONE;
                    unique case (op)
                        lc3_iec_pkg::OP_BR: begin
                            if (dr == '0 || (dr & cc_reg) != '0) begin
                                pc_next = pc1 + off9;
                            end
                        end
                        lc3_iec_pkg::OP_ADD, lc3_iec_pkg::OP_AND, lc3_iec_pkg::OP_NOT,
                        lc3_iec_pkg::OP_LEA: begin
                            unique case (op)
                                lc3_iec_pkg::OP_ADD: v = rd_a + src2;
                                lc3_iec_pkg::OP_AND: v = rd_a & src2;
                                lc3_iec_pkg::OP_NOT: v = ~rd_a;
                                default:             v = pc1 + off9;
                            endcase
                            gr_we   = 1'b1;
                            gr_wi   = dr;
                            gr_wd   = v;
                            cc_next = flags_of(v);
                            res0.dest_written = 1'b1;
                            res0.dest_index   = dr;
                            res0.dest_value   = v;
                        end
                        lc3_iec_pkg::OP_LD, lc3_iec_pkg::OP_LDR, lc3_iec_pkg::OP_LDI: begin
                            pend_next = (op == lc3_iec_pkg::OP_LDI) ?
                                        lc3_iec_pkg::PEND_LDI_PTR : lc3_iec_pkg::PEND_LOAD;
                            preg_next = dr;
                            res0.req_kind    = lc3_iec_pkg::KIND_READ;
                            res0.req_address = (op == lc3_iec_pkg::OP_LDR) ?
                                               rd_a + off6 : pc1 + off9;
                        end
                        lc3_iec_pkg::OP_ST, lc3_iec_pkg::OP_STR: begin
                            res0.req_kind    = lc3_iec_pkg::KIND_WRITE;
                            res0.req_address = (op == lc3_iec_pkg::OP_STR) ?
                                               rd_a + off6 : pc1 + off9;
                            res0.write_data  = rd_c;
                        end
                        lc3_iec_pkg::OP_STI: begin
                            pend_next = lc3_iec_pkg::PEND_STI_PTR;
                            preg_next = dr;
                            res0.req_kind    = lc3_iec_pkg::KIND_READ;
                            res0.req_address = pc1 + off9;
                        end
                        lc3_iec_pkg::OP_JSR: begin
                            pc_next = in_word_reg[11] ? pc1 + off11 : rd_a;
                            gr_we   = 1'b1;
                            gr_wi   = lc3_iec_pkg::REG_LINK;
                            gr_wd   = pc1;
                            res0.dest_written = 1'b1;
                            res0.dest_index   = lc3_iec_pkg::REG_LINK;
                            res0.dest_value   = pc1;
                        end
                        lc3_iec_pkg::OP_JMP: begin
                            pc_next = rd_a;
                        end
                        lc3_iec_pkg::OP_RTI: begin
                            v         = sp - 16'd1;
                            gr_we     = 1'b1;
                            gr_wi     = lc3_iec_pkg::REG_SP;
                            gr_wd     = v;
                            pend_next = lc3_iec_pkg::PEND_RTI;
                            res0.req_kind     = lc3_iec_pkg::KIND_READ;
                            res0.req_address  = v;
                            res0.dest_written = 1'b1;
                            res0.dest_index   = lc3_iec_pkg::REG_SP;
                            res0.dest_value   = v;
                        end
                        lc3_iec_pkg::OP_RSV: begin
                            pc_next = ill_vec_reg;
                        end
                        default: begin
                            // trap runs as a no-op
                        end
                    endcase
                end
            end
            lc3_iec_pkg::CMD_DATA: begin
                pend_next = lc3_iec_pkg::PEND_NONE;
                unique case (pend_reg)
                    lc3_iec_pkg::PEND_LOAD: begin
                        push_n  = 2'd1;
                        gr_we   = 1'b1;
                        gr_wi   = preg_reg;
                        gr_wd   = in_word_reg;
                        cc_next = flags_of(in_word_reg);
                        res0.req_kind     = lc3_iec_pkg::KIND_DONE;
                        res0.dest_written = 1'b1;
                        res0.dest_index   = preg_reg;
                        res0.dest_value   = in_word_reg;
                    end
                    lc3_iec_pkg::PEND_LDI_PTR: begin
                        push_n    = 2'd1;
                        pend_next = lc3_iec_pkg::PEND_LOAD;
                        res0.req_kind    = lc3_iec_pkg::KIND_READ;
                        res0.req_address = in_word_reg;
                    end
                    lc3_iec_pkg::PEND_STI_PTR: begin
                        push_n = 2'd1;
                        res0.req_kind    = lc3_iec_pkg::KIND_WRITE;
                        res0.req_address = in_word_reg;
                        res0.write_data  = rd_c;
                    end
                    lc3_iec_pkg::PEND_RTI: begin
                        push_n  = 2'd1;
                        pc_next = in_word_reg;
                        ie_next = 1'b1;
                        res0.req_kind = lc3_iec_pkg::KIND_DONE;
                    end
                    default: begin
                        // nothing pending
                    end
                endcase
            end
            default: begin
                // unused command
            end
        endcase

        res0.pc_value   = pc_next;
        res0.cond_flags = cc_next;
        res1.pc_value   = pc_next;
        res1.cond_flags = cc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            pc_reg      <= '0;
            cc_reg      <= lc3_iec_pkg::CC_Z;
            ie_reg      <= 1'b0;
            pend_reg    <= lc3_iec_pkg::PEND_NONE;
            preg_reg    <= '0;
            irq_vec_reg <= lc3_iec_pkg::IRQ_VEC_RESET;
            ill_vec_reg <= lc3_iec_pkg::ILL_VEC_RESET;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            cnt_reg     <= '0;
            for (int i = 0; i < NREGS; i++) begin
                gr_reg[i] <= '0;
            end
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (exec_go) begin
                in_vld_reg <= 1'b0;
            end
            if (exec_go) begin
                pc_reg     <= pc_next;
                cc_reg     <= cc_next;
                ie_reg     <= ie_next;
                pend_reg   <= pend_next;
                preg_reg   <= preg_next;
                if (gr_we) begin
                    gr_reg[gr_wi] <= gr_wd;
                end
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == lc3_iec_pkg::CFG_IRQ_VEC) begin
                    irq_vec_reg <= cfg_data;
                end else if (cfg_index == lc3_iec_pkg::CFG_ILL_VEC) begin
                    ill_vec_reg <= cfg_data;
                end
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_reg + CNT_W'(exec_go ? push_n : 2'd0) - CNT_W'(pop);
        end
    end

    // input register payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg  <= s_cmd;
            in_word_reg <= s_data_word;
            in_irq_reg  <= s_irq_request;
        end
    end

    // result queue payload
    always_ff @(posedge aclk) begin
        if (exec_go && push_n != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (exec_go && push_n == 2'd2) begin
            fifo_reg[PTR_W'(wr_ptr_reg + PTR_W'(1))] <= res1;
        end
    end

    assign m_valid        = (cnt_reg != '0);
    assign m_req_kind     = fifo_reg[rd_ptr_reg].req_kind;
    assign m_req_address  = fifo_reg[rd_ptr_reg].req_address;
    assign m_write_data   = fifo_reg[rd_ptr_reg].write_data;
    assign m_pc_value     = fifo_reg[rd_ptr_reg].pc_value;
    assign m_cond_flags   = fifo_reg[rd_ptr_reg].cond_flags;
    assign m_dest_written = fifo_reg[rd_ptr_reg].dest_written;
    assign m_dest_index   = fifo_reg[rd_ptr_reg].dest_index;
    assign m_dest_value   = fifo_reg[rd_ptr_reg].dest_value;
    assign m_last         = fifo_reg[rd_ptr_reg].last;

endmodule

`default_nettype wire

@@ rtl/core/lc3_iec_checker.sv @@
// ----------------------------------------------------------------------------
// lc3_iec_checker
// Port-level checks of the LC-3 instruction execute core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module lc3_iec_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                m_valid,
    input  wire logic                                m_ready,
    input  wire logic [lc3_iec_pkg::KIND_W-1:0]      m_req_kind,
    input  wire logic [lc3_iec_pkg::WORD_W-1:0]      m_req_address,
    input  wire logic [lc3_iec_pkg::WORD_W-1:0]      m_pc_value,
    input  wire logic [lc3_iec_pkg::FLAGS_W-1:0]     m_cond_flags,
    input  wire logic                                m_dest_written,
    input  wire logic [lc3_iec_pkg::RIDX_W-1:0]      m_dest_index,
    input  wire logic [lc3_iec_pkg::WORD_W-1:0]      m_dest_value,
    input  wire logic                                m_last
);

    // a stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_req_kind)
            && $stable(m_req_address) && $stable(m_pc_value) && $stable(m_last))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // only the interrupt push is followed by a second result
    a_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_req_kind == lc3_iec_pkg::KIND_WRITE
            && m_dest_written && m_dest_index == lc3_iec_pkg::REG_SP)
        else $error("non-final result is not an interrupt push");

    a_dest_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_dest_written |-> m_dest_index == '0 && m_dest_value == '0)
        else $error("destination fields set without a register write");

    a_fetch_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_req_kind == lc3_iec_pkg::KIND_FETCH |->
            m_req_address == m_pc_value && m_last && $onehot(m_cond_flags))
        else $error("fetch address differs from pc");

endmodule

bind lc3_instruction_execute_core_top lc3_iec_checker u_lc3_iec_checker (.*);

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LC-3 instruction execute core. A scoreboard
// class keeps its own copy of registers, PC, flags, interrupt enable and the
// pending access, and predicts the fetch, read, write and completion results
// of every item that the core accepts. A directed pass walks every opcode,
// the flag extremes, LDI/STI pointers, RTI and an interrupt; random programs
// follow under several vector settings with random gaps on both channels
// and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_AT        = 80;
    localparam int HOLD_CYCLES    = 400;
    localparam int IDLE_PAUSE     = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASE_ITEMS    = 92;

    localparam logic [lc3_iec_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [lc3_iec_pkg::KIND_W-1:0]  kind;
        logic [lc3_iec_pkg::WORD_W-1:0]  addr;
        logic [lc3_iec_pkg::WORD_W-1:0]  wdata;
        logic [lc3_iec_pkg::WORD_W-1:0]  pc;
        logic [lc3_iec_pkg::FLAGS_W-1:0] flags;
        logic                            dw;
        logic [lc3_iec_pkg::RIDX_W-1:0]  di;
        logic [lc3_iec_pkg::WORD_W-1:0]  dv;
        logic                            last;
    } core_result_t;

    class core_scoreboard;
        core_result_t                    expected_q[$];
        logic [lc3_iec_pkg::WORD_W-1:0]  gpr[8];
        logic [lc3_iec_pkg::WORD_W-1:0]  pc_reg;
        logic [lc3_iec_pkg::FLAGS_W-1:0] cc_reg;
        logic                            irq_en;
        logic [lc3_iec_pkg::PEND_W-1:0]  pend_kind;
        logic [lc3_iec_pkg::RIDX_W-1:0]  pend_dst;
        logic [lc3_iec_pkg::WORD_W-1:0]  irq_vec;
        logic [lc3_iec_pkg::WORD_W-1:0]  ill_vec;
        int unsigned                     errors;

        function new();
            foreach (gpr[i]) gpr[i] = '0;
            pc_reg    = '0;
            cc_reg    = lc3_iec_pkg::CC_Z;
            irq_en    = 1'b0;
            pend_kind = lc3_iec_pkg::PEND_NONE;
            pend_dst  = '0;
            irq_vec   = lc3_iec_pkg::IRQ_VEC_RESET;
            ill_vec   = lc3_iec_pkg::ILL_VEC_RESET;
            errors    = 0;
        endfunction

        function void set_vector(logic [lc3_iec_pkg::CFG_IDX_W-1:0] idx,
                                 logic [lc3_iec_pkg::WORD_W-1:0] val);
            if (idx == lc3_iec_pkg::CFG_IRQ_VEC) begin
                irq_vec = val;
            end else if (idx == lc3_iec_pkg::CFG_ILL_VEC) begin
                ill_vec = val;
            end
        endfunction

        function void set_cc(logic [lc3_iec_pkg::WORD_W-1:0] v);
            if (v[lc3_iec_pkg::WORD_W-1]) begin
                cc_reg = lc3_iec_pkg::CC_N;
            end else if (v == '0) begin
                cc_reg = lc3_iec_pkg::CC_Z;
            end else begin
                cc_reg = lc3_iec_pkg::CC_P;
            end
        endfunction

        function void add_result(logic [lc3_iec_pkg::KIND_W-1:0] kind,
                                 logic [lc3_iec_pkg::WORD_W-1:0] addr,
                                 logic [lc3_iec_pkg::WORD_W-1:0] wdata, logic dw,
                                 logic [lc3_iec_pkg::RIDX_W-1:0] di,
                                 logic [lc3_iec_pkg::WORD_W-1:0] dv,
                                 logic last);
            core_result_t r;
            r.kind  = kind;
            r.addr  = addr;
            r.wdata = wdata;
            r.pc    = pc_reg;
            r.flags = cc_reg;
            r.dw    = dw;
            r.di    = dw ? di : '0;
            r.dv    = dw ? dv : '0;
            r.last  = last;
            expected_q.push_back(r);
        endfunction

        function void exec_word(logic [lc3_iec_pkg::WORD_W-1:0] w);
            logic [lc3_iec_pkg::OP_W-1:0]   op;
            logic [lc3_iec_pkg::RIDX_W-1:0] dr;
            logic [lc3_iec_pkg::RIDX_W-1:0] sr1;
            logic [lc3_iec_pkg::WORD_W-1:0] src2;
            logic [lc3_iec_pkg::WORD_W-1:0] off9;
            logic [lc3_iec_pkg::WORD_W-1:0] off6;
            logic [lc3_iec_pkg::WORD_W-1:0] off11;
            logic [lc3_iec_pkg::WORD_W-1:0] v;
            logic [lc3_iec_pkg::WORD_W-1:0] a;
            op    = w[15:12];
            dr    = w[11:9];
            sr1   = w[8:6];
            off9  = {{7{w[8]}}, w[8:0]};
            off6  = {{10{w[5]}}, w[5:0]};
            off11 = {{5{w[10]}}, w[10:0]};
            src2  = w[5] ? {{11{w[4]}}, w[4:0]} : gpr[w[2:0]];
            pc_reg = pc_reg + 16'd1;
            case (op)
                lc3_iec_pkg::OP_BR: begin
                    if (dr == 3'b000 || (dr & cc_reg) != 3'b000) pc_reg = pc_reg + off9;
                    add_result(lc3_iec_pkg::KIND_DONE, '0, '0, 1'b0, '0, '0, 1'b1);
                end
                lc3_iec_pkg::OP_ADD, lc3_iec_pkg::OP_AND, lc3_iec_pkg::OP_NOT: begin
                    if (op == lc3_iec_pkg::OP_ADD) begin
                        v = gpr[sr1] + src2;
                    end else if (op == lc3_iec_pkg::OP_AND) begin
                        v = gpr[sr1] & src2;
                    end else begin
                        v = ~gpr[sr1];
                    end
                    gpr[dr] = v;
                    set_cc(v);
                    add_result(lc3_iec_pkg::KIND_DONE, '0, '0, 1'b1, dr, v, 1'b1);
                end
                lc3_iec_pkg::OP_LEA: begin
                    v = pc_reg + off9;
                    gpr[dr] = v;
                    set_cc(v);
                    add_result(lc3_iec_pkg::KIND_DONE, '0, '0, 1'b1, dr, v, 1'b1);
                end
                lc3_iec_pkg::OP_LD, lc3_iec_pkg::OP_LDR, lc3_iec_pkg::OP_LDI: begin
                    a = (op == lc3_iec_pkg::OP_LDR) ? gpr[sr1] + off6 : pc_reg + off9;
                    pend_kind = (op == lc3_iec_pkg::OP_LDI) ?
                                lc3_iec_pkg::PEND_LDI_PTR : lc3_iec_pkg::PEND_LOAD;
                    pend_dst  = dr;
                    add_result(lc3_iec_pkg::KIND_READ, a, '0, 1'b0, '0, '0, 1'b1);
                end
                lc3_iec_pkg::OP_ST, lc3_iec_pkg::OP_STR: begin
                    a = (op == lc3_iec_pkg::OP_STR) ? gpr[sr1] + off6 : pc_reg + off9;
                    add_result(lc3_iec_pkg::KIND_WRITE, a, gpr[dr], 1'b0, '0, '0, 1'b1);
                end
                lc3_iec_pkg::OP_STI: begin
                    pend_kind = lc3_iec_pkg::PEND_STI_PTR;
                    pend_dst  = dr;
                    add_result(lc3_iec_pkg::KIND_READ, pc_reg + off9, '0, 1'b0, '0, '0,
                               1'b1);
                end
                lc3_iec_pkg::OP_JSR: begin
                    v = pc_reg;
                    pc_reg = w[11] ? pc_reg + off11 : gpr[sr1];
                    gpr[lc3_iec_pkg::REG_LINK] = v;
                    add_result(lc3_iec_pkg::KIND_DONE, '0, '0, 1'b1, lc3_iec_pkg::REG_LINK,
                               v, 1'b1);
                end
                lc3_iec_pkg::OP_JMP: begin
                    pc_reg = gpr[sr1];
                    add_result(lc3_iec_pkg::KIND_DONE, '0, '0, 1'b0, '0, '0, 1'b1);
                end
                lc3_iec_pkg::OP_RTI: begin
                    v = gpr[lc3_iec_pkg::REG_SP] - 16'd1;
                    gpr[lc3_iec_pkg::REG_SP] = v;
                    pend_kind = lc3_iec_pkg::PEND_RTI;
                    add_result(lc3_iec_pkg::KIND_READ, v, '0, 1'b1, lc3_iec_pkg::REG_SP,
                               v, 1'b1);
                end
                lc3_iec_pkg::OP_RSV: begin
                    pc_reg = ill_vec;
                    add_result(lc3_iec_pkg::KIND_DONE, '0, '0, 1'b0, '0, '0, 1'b1);
                end
                default: begin
                    add_result(lc3_iec_pkg::KIND_DONE, '0, '0, 1'b0, '0, '0, 1'b1);
                end
            endcase
        endfunction

        function int execute_item(logic [lc3_iec_pkg::CMD_W-1:0] cmd,
                                  logic [lc3_iec_pkg::WORD_W-1:0] w, logic irq);
            int                             start_size;
            logic [lc3_iec_pkg::PEND_W-1:0] p;
            logic [lc3_iec_pkg::WORD_W-1:0] a;
            logic [lc3_iec_pkg::WORD_W-1:0] saved;
            start_size = expected_q.size();
            case (cmd)
                lc3_iec_pkg::CMD_STEP: begin
                    if (pend_kind == lc3_iec_pkg::PEND_NONE) begin
                        if (irq_en && irq) begin
                            a     = gpr[lc3_iec_pkg::REG_SP];
                            saved = pc_reg;
                            gpr[lc3_iec_pkg::REG_SP] = a + 16'd1;
                            irq_en = 1'b0;
                            pc_reg = irq_vec;
                            add_result(lc3_iec_pkg::KIND_WRITE, a, saved, 1'b1,
                                       lc3_iec_pkg::REG_SP, gpr[lc3_iec_pkg::REG_SP], 1'b0);
                        end
                        add_result(lc3_iec_pkg::KIND_FETCH, pc_reg, '0, 1'b0, '0, '0, 1'b1);
                    end
                end
                lc3_iec_pkg::CMD_INSTR: begin
                    if (pend_kind == lc3_iec_pkg::PEND_NONE) exec_word(w);
                end
                lc3_iec_pkg::CMD_DATA: begin
                    p = pend_kind;
                    pend_kind = lc3_iec_pkg::PEND_NONE;
                    case (p)
                        lc3_iec_pkg::PEND_LOAD: begin
                            gpr[pend_dst] = w;
                            set_cc(w);
                            add_result(lc3_iec_pkg::KIND_DONE, '0, '0, 1'b1, pend_dst, w,
                                       1'b1);
                        end
                        lc3_iec_pkg::PEND_LDI_PTR: begin
                            pend_kind = lc3_iec_pkg::PEND_LOAD;
                            add_result(lc3_iec_pkg::KIND_READ, w, '0, 1'b0, '0, '0, 1'b1);
                        end
                        lc3_iec_pkg::PEND_STI_PTR: begin
                            add_result(lc3_iec_pkg::KIND_WRITE, w, gpr[pend_dst], 1'b0, '0,
                                       '0, 1'b1);
                        end
                        lc3_iec_pkg::PEND_RTI: begin
                            pc_reg = w;
                            irq_en = 1'b1;
                            add_result(lc3_iec_pkg::KIND_DONE, '0, '0, 1'b0, '0, '0, 1'b1);
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
            return expected_q.size() - start_size;
        endfunction

        function void compare_field(string name, logic [lc3_iec_pkg::WORD_W-1:0] want,
                                    logic [lc3_iec_pkg::WORD_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(core_result_t got);
            core_result_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, kind %h addr %h pc %h", $time,
                         got.kind, got.addr, got.pc);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("req_kind", 16'(want.kind), 16'(got.kind));
            compare_field("req_address", want.addr, got.addr);
            compare_field("write_data", want.wdata, got.wdata);
            compare_field("pc_value", want.pc, got.pc);
            compare_field("cond_flags", 16'(want.flags), 16'(got.flags));
            compare_field("dest_written", 16'(want.dw), 16'(got.dw));
            compare_field("dest_index", 16'(want.di), 16'(got.di));
            compare_field("dest_value", want.dv, got.dv);
            compare_field("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    logic                                 aclk;
    logic                                 aresetn       = 1'b0;
    logic                                 s_valid       = 1'b0;
    logic                                 s_ready;
    logic [lc3_iec_pkg::CMD_W-1:0]        s_cmd         = '0;
    logic [lc3_iec_pkg::WORD_W-1:0]       s_data_word   = '0;
    logic                                 s_irq_request = 1'b0;
    logic                                 m_valid;
    logic                                 m_ready       = 1'b0;
    logic [lc3_iec_pkg::KIND_W-1:0]       m_req_kind;
    logic [lc3_iec_pkg::WORD_W-1:0]       m_req_address;
    logic [lc3_iec_pkg::WORD_W-1:0]       m_write_data;
    logic [lc3_iec_pkg::WORD_W-1:0]       m_pc_value;
    logic [lc3_iec_pkg::FLAGS_W-1:0]      m_cond_flags;
    logic                                 m_dest_written;
    logic [lc3_iec_pkg::RIDX_W-1:0]       m_dest_index;
    logic [lc3_iec_pkg::WORD_W-1:0]       m_dest_value;
    logic                                 m_last;
    logic                                 cfg_valid     = 1'b0;
    logic                                 cfg_ready;
    logic [lc3_iec_pkg::CFG_IDX_W-1:0]    cfg_index     = '0;
    logic [lc3_iec_pkg::WORD_W-1:0]       cfg_data      = '0;

    core_scoreboard sb = new();
    int counted_items = 0;
    int results_seen  = 0;
    int s_calm        = 0;
    int m_calm        = 0;

    lc3_instruction_execute_core_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_data_word    (s_data_word),
        .s_irq_request  (s_irq_request),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_req_kind     (m_req_kind),
        .m_req_address  (m_req_address),
        .m_write_data   (m_write_data),
        .m_pc_value     (m_pc_value),
        .m_cond_flags   (m_cond_flags),
        .m_dest_written (m_dest_written),
        .m_dest_index   (m_dest_index),
        .m_dest_value   (m_dest_value),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int pick_gap(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if (r < 2) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [lc3_iec_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'h8000;
            2: return 16'hFFFF;
            3: return 16'h7FFF;
            default: return lc3_iec_pkg::WORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [lc3_iec_pkg::WORD_W-1:0] enc9(
        logic [lc3_iec_pkg::OP_W-1:0] op, logic [2:0] r, logic [8:0] off);
        return {op, r, off};
    endfunction

    function automatic logic [lc3_iec_pkg::WORD_W-1:0] enc6(
        logic [lc3_iec_pkg::OP_W-1:0] op, logic [2:0] r, logic [2:0] base,
        logic [5:0] low);
        return {op, r, base, low};
    endfunction

    task automatic send_item(input logic [lc3_iec_pkg::CMD_W-1:0] cmd,
                             input logic [lc3_iec_pkg::WORD_W-1:0] w,
                             input logic irq);
        int g;
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_data_word   <= w;
        s_irq_request <= irq;
        do @(posedge aclk); while (!s_ready);
        if (sb.execute_item(cmd, w, irq) > 0) counted_items++;
        g = pick_gap(s_calm);
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic settle(input int cycles);
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic write_vectors(input logic [lc3_iec_pkg::WORD_W-1:0] irq_v,
                                 input logic [lc3_iec_pkg::WORD_W-1:0] ill_v);
        cfg_valid <= 1'b1;
        cfg_index <= lc3_iec_pkg::CFG_IRQ_VEC;
        cfg_data  <= irq_v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_vector(lc3_iec_pkg::CFG_IRQ_VEC, irq_v);
        cfg_index <= lc3_iec_pkg::CFG_ILL_VEC;
        cfg_data  <= ill_v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_vector(lc3_iec_pkg::CFG_ILL_VEC, ill_v);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        send_item(lc3_iec_pkg::CMD_STEP, '0, 1'b1);
        send_item(lc3_iec_pkg::CMD_INSTR,
                  enc6(lc3_iec_pkg::OP_ADD, 3'd1, 3'd0, {1'b1, 5'h10}), 1'b0);
        send_item(lc3_iec_pkg::CMD_INSTR,
                  enc6(lc3_iec_pkg::OP_ADD, 3'd2, 3'd0, {1'b1, 5'h0F}), 1'b0);
        send_item(lc3_iec_pkg::CMD_INSTR,
                  enc6(lc3_iec_pkg::OP_AND, 3'd3, 3'd1, {1'b1, 5'h00}), 1'b0);
        send_item(lc3_iec_pkg::CMD_INSTR,
                  enc6(lc3_iec_pkg::OP_ADD, 3'd4, 3'd1, {3'b000, 3'd2}), 1'b0);
        send_item(lc3_iec_pkg::CMD_INSTR,
                  enc6(lc3_iec_pkg::OP_NOT, 3'd6, 3'd2, 6'h3F), 1'b0);
        send_item(lc3_iec_pkg::CMD_INSTR, enc9(lc3_iec_pkg::OP_LEA, 3'd0, 9'h0FF), 1'b0);
        // branch with no condition bits is taken
        send_item(lc3_iec_pkg::CMD_INSTR, enc9(lc3_iec_pkg::OP_BR, 3'b000, 9'h100), 1'b0);
        send_item(lc3_iec_pkg::CMD_INSTR,
                  enc9(lc3_iec_pkg::OP_BR, lc3_iec_pkg::CC_Z, 9'h0FF), 1'b0);
        send_item(lc3_iec_pkg::CMD_INSTR,
                  enc9(lc3_iec_pkg::OP_BR, lc3_iec_pkg::CC_P, 9'h001), 1'b0);
        send_item(lc3_iec_pkg::CMD_INSTR, enc9(lc3_iec_pkg::OP_LD, 3'd1, 9'h0FF), 1'b0);
        send_item(lc3_iec_pkg::CMD_DATA, 16'h8000, 1'b0);
        // step and unused command ignored while a load is open
        send_item(lc3_iec_pkg::CMD_INSTR,
                  enc6(lc3_iec_pkg::OP_LDR, 3'd2, 3'd6, 6'h20), 1'b0);
        send_item(lc3_iec_pkg::CMD_STEP, '0, 1'b0);
        send_item(CMD_UNUSED, 16'hFFFF, 1'b1);
        send_item(lc3_iec_pkg::CMD_DATA, 16'h0000, 1'b0);
        send_item(lc3_iec_pkg::CMD_INSTR, enc9(lc3_iec_pkg::OP_LDI, 3'd3, 9'h100), 1'b0);
        send_item(lc3_iec_pkg::CMD_DATA, 16'hFFFF, 1'b0);
        send_item(lc3_iec_pkg::CMD_DATA, 16'h7FFF, 1'b0);
        send_item(lc3_iec_pkg::CMD_INSTR, enc9(lc3_iec_pkg::OP_ST, 3'd1, 9'h1FF), 1'b0);
        send_item(lc3_iec_pkg::CMD_INSTR,
                  enc6(lc3_iec_pkg::OP_STR, 3'd2, 3'd0, 6'h1F), 1'b0);
        send_item(lc3_iec_pkg::CMD_INSTR, enc9(lc3_iec_pkg::OP_STI, 3'd4, 9'h000), 1'b0);
        send_item(lc3_iec_pkg::CMD_DATA, 16'hFFFE, 1'b0);
        send_item(lc3_iec_pkg::CMD_INSTR, {lc3_iec_pkg::OP_JSR, 1'b1, 11'h400}, 1'b0);
        send_item(lc3_iec_pkg::CMD_INSTR,
                  enc6(lc3_iec_pkg::OP_JSR, 3'b000, 3'd1, 6'h00), 1'b0);
        send_item(lc3_iec_pkg::CMD_INSTR,
                  enc6(lc3_iec_pkg::OP_JMP, 3'b000, lc3_iec_pkg::REG_LINK, 6'h00), 1'b0);
        send_item(lc3_iec_pkg::CMD_INSTR, {lc3_iec_pkg::OP_RSV, 12'hABC}, 1'b0);
        send_item(lc3_iec_pkg::CMD_INSTR, {lc3_iec_pkg::OP_TRAP, 12'h0FF}, 1'b0);
        // read data with nothing open is dropped
        send_item(lc3_iec_pkg::CMD_DATA, 16'h1234, 1'b0);
        send_item(lc3_iec_pkg::CMD_INSTR, {lc3_iec_pkg::OP_RTI, 12'h000}, 1'b0);
        send_item(lc3_iec_pkg::CMD_DATA, 16'h3000, 1'b0);
        send_item(lc3_iec_pkg::CMD_STEP, '0, 1'b0);
        send_item(lc3_iec_pkg::CMD_STEP, '0, 1'b1);
    endtask

    task automatic run_random(input int count);
        int                             start;
        int                             r;
        logic [lc3_iec_pkg::CMD_W-1:0]  cmd;
        logic [lc3_iec_pkg::WORD_W-1:0] w;
        logic                           irq;
        bit                             fetched;
        start   = counted_items;
        fetched = 1'b0;
        while (counted_items - start < count) begin
            r   = $urandom_range(0, 99);
            irq = 1'($urandom_range(0, 1));
            if (sb.pend_kind != lc3_iec_pkg::PEND_NONE) begin
                cmd = (r < 85) ? lc3_iec_pkg::CMD_DATA
                               : lc3_iec_pkg::CMD_W'($urandom_range(0, 3));
            end else if (r < 4) begin
                cmd = lc3_iec_pkg::CMD_DATA;
            end else if (r < 7) begin
                cmd = CMD_UNUSED;
            end else if (r < 10 || fetched) begin
                cmd = lc3_iec_pkg::CMD_INSTR;
                fetched = 1'b0;
            end else begin
                cmd = lc3_iec_pkg::CMD_STEP;
                fetched = 1'b1;
            end
            w = (cmd == lc3_iec_pkg::CMD_INSTR) ? lc3_iec_pkg::WORD_W'($urandom)
                                                : pick_word();
            send_item(cmd, w, irq);
        end
    endtask

    // result side with random stalls and one long hold-off
    initial begin
        core_result_t got;
        bit           held;
        int           g;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.kind  = m_req_kind;
                got.addr  = m_req_address;
                got.wdata = m_write_data;
                got.pc    = m_pc_value;
                got.flags = m_cond_flags;
                got.dw    = m_dest_written;
                got.di    = m_dest_index;
                got.dv    = m_dest_value;
                got.last  = m_last;
                sb.check_result(got);
                results_seen++;
            end
            if (!held && results_seen >= HOLD_AT) begin
                held = 1'b1;
                g = HOLD_CYCLES;
            end else begin
                g = pick_gap(m_calm);
            end
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        run_directed();
        settle(IDLE_PAUSE);
        write_vectors(16'h0000, 16'hFFFF);
        run_random(PHASE_ITEMS);
        settle(IDLE_PAUSE);
        write_vectors(16'hFFFF, 16'h0000);
        run_random(PHASE_ITEMS);
        settle(IDLE_PAUSE);
        write_vectors(lc3_iec_pkg::WORD_W'($urandom), lc3_iec_pkg::WORD_W'($urandom));
        run_random(PHASE_ITEMS);
        settle(IDLE_PAUSE);
        write_vectors(lc3_iec_pkg::WORD_W'($urandom), lc3_iec_pkg::WORD_W'($urandom));
        run_random(PHASE_ITEMS);
        settle(DRAIN_CYCLES);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
